// ===== rtl/core/wbps_pkg.sv =====
// Shared constants and types for the wildcard byte pattern scanner.
package wbps_pkg;

  // Window depth and position counter width
  localparam int MAX_PATTERN = 16;
  localparam int OFFSET_BITS = 32;

  // Fixed pattern storage and field widths
  localparam int PAT_BYTES  = 16;
  localparam int PAT_LIMIT  = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
  localparam int PAT_IDX_W  = $clog2(PAT_BYTES);
  localparam int LEN_W      = 5;
  localparam int OUT_OFF_W  = 32;
  localparam int ADDR_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd4;

  // Byte window, entry 0 is the newest byte
  typedef logic [MAX_PATTERN-1:0][7:0] window_t;

  // Live configuration
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [PAT_BYTES-1:0]      care;
    logic [LEN_W-1:0]          length;
    logic [ADDR_W-1:0]         base;
  } cfg_t;

  // Per-item data carried from the window stage to the match stage
  typedef struct packed {
    logic                   eligible;
    logic [OFFSET_BITS-1:0] off;
  } stage_t;

endpackage

// ===== rtl/core/wbps_cfg.sv =====
// Configuration register file for the scanner.
module wbps_cfg
  import wbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  logic [63:0]          pat_low_r;
  logic [63:0]          pat_high_r;
  logic [PAT_BYTES-1:0] care_r;
  logic [LEN_W-1:0]     length_r;
  logic [ADDR_W-1:0]    base_r;

  // Write the addressed register, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      care_r     <= '0;
      length_r   <= '0;
      base_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAT_LOW:  pat_low_r  <= cfg_wdata[63:0];
        CFG_PAT_HIGH: pat_high_r <= cfg_wdata[63:0];
        CFG_CARE:     care_r     <= cfg_wdata[PAT_BYTES-1:0];
        CFG_LENGTH:   length_r   <= cfg_wdata[LEN_W-1:0];
        CFG_BASE:     base_r     <= cfg_wdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.pattern = {pat_high_r, pat_low_r};
  assign cfg.care    = care_r;
  assign cfg.length  = length_r;
  assign cfg.base    = base_r;

endmodule

// ===== rtl/core/wbps_window.sv =====
// Input stage: byte window, region position counter and match eligibility.
module wbps_window
  import wbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_of_region,
  input  cfg_t       cfg,
  input  logic       take,
  output logic       s1_valid,
  output stage_t     s1,
  output window_t    window
);

  window_t                win_r;
  window_t                win_nxt;
  logic [OFFSET_BITS-1:0] seen_r;
  logic [OFFSET_BITS-1:0] seen_nxt;
  logic                   s1_valid_r;
  stage_t                 s1_r;
  stage_t                 s1_nxt;
  logic [OFFSET_BITS:0]   pos_inc;
  logic                   accept;

  // Take a new item whenever the stage is empty or draining this cycle
  assign in_ready = !s1_valid_r || take;
  assign accept   = in_valid && in_ready;

  // Shift the new byte in at the newest end
  always_comb begin
    win_nxt[0] = in_byte_value;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // Work out whether a full pattern fits and where it would start
  assign pos_inc = {1'b0, seen_r} + (OFFSET_BITS+1)'(1);

  always_comb begin
    s1_nxt.eligible = (cfg.length != '0) && (cfg.length <= LEN_W'(PAT_LIMIT)) &&
                      (pos_inc >= (OFFSET_BITS+1)'(cfg.length));
    s1_nxt.off      = OFFSET_BITS'(pos_inc - (OFFSET_BITS+1)'(cfg.length));
  end

  // Clear on region end, saturate at the top of the range
  always_comb begin
    seen_nxt = seen_r;
    if (in_last_of_region) begin
      seen_nxt = '0;
    end else if (seen_r != '1) begin
      seen_nxt = seen_r + OFFSET_BITS'(1);
    end
  end

  // Advance window, counter and stage register on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      seen_r     <= '0;
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      win_r      <= win_nxt;
      seen_r     <= seen_nxt;
      s1_valid_r <= 1'b1;
    end else if (take) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Hold the per-item payload alongside the window
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign window   = win_r;

`ifndef SYNTHESIS
  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_of_region |=> seen_r == '0)
    else $error("position count not cleared after region end");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_last_of_region && (seen_r != '1) |=>
      seen_r == OFFSET_BITS'($past(seen_r) + OFFSET_BITS'(1)))
    else $error("position count did not advance by one");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !take |=> s1_valid_r && $stable(s1_r) && $stable(win_r))
    else $error("stalled stage item changed");
`endif

endmodule

// ===== rtl/core/wbps_match.sv =====
// Match stage: wildcard window compare, address add and result register.
module wbps_match
  import wbps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  stage_t               s1,
  input  window_t              window,
  input  cfg_t                 cfg,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_OFF_W-1:0] out_match_offset,
  output logic [ADDR_W-1:0]    out_match_address
);

  logic                 out_valid_r;
  logic [OUT_OFF_W-1:0] offset_r;
  logic [ADDR_W-1:0]    address_r;
  logic [PAT_LIMIT-1:0] miss;
  logic                 hit;

  // Compare each window byte with the pattern byte it lines up with
  always_comb begin
    logic [LEN_W-1:0]     j_full;
    logic [PAT_IDX_W-1:0] j;
    logic                 in_use;
    miss = '0;
    for (int i = 0; i < PAT_LIMIT; i++) begin
      j_full  = cfg.length - LEN_W'(1) - LEN_W'(i);
      j       = j_full[PAT_IDX_W-1:0];
      in_use  = LEN_W'(i) < cfg.length;
      miss[i] = in_use && cfg.care[j] && (window[i] != cfg.pattern[j]);
    end
  end

  assign hit = s1.eligible && (miss == '0);

  // Move the stage item on whenever the result register is free
  assign take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= s1_valid && hit;
    end
  end

  // Load offset and base-plus-offset address on a hit
  always_ff @(posedge clk) begin
    if (take && s1_valid && hit) begin
      offset_r  <= OUT_OFF_W'(s1.off);
      address_r <= cfg.base + ADDR_W'(s1.off);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_offset  = offset_r;
  assign out_match_address = address_r;

`ifndef SYNTHESIS
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid))
    else $error("result appeared without a stage item");

  a_no_hit_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    take && !(s1_valid && hit) |=> !out_valid_r)
    else $error("result raised without a match");

  a_ineligible: assert property (@(posedge clk) disable iff (!rst_n)
    take && s1_valid && !s1.eligible |=> !out_valid_r)
    else $error("result raised for a short region");
`endif

endmodule

// ===== rtl/core/wildcard_byte_pattern_scanner_unit.sv =====
// Top level of the wildcard byte pattern scanner.
// A match moves from the window stage register into the result register once that register is free.
// Throughput: one byte per cycle while no stall holds the input.
// A full result register stalls the input only when the stage behind it is full.
// Reset (synchronous, active low) clears the window, position count and config.
module wildcard_byte_pattern_scanner_unit
  import wbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte_value,
  input  logic                  in_last_of_region,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_OFF_W-1:0]  out_match_offset,
  output logic [ADDR_W-1:0]     out_match_address,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  logic    take;
  logic    s1_valid;
  stage_t  s1;
  window_t window;

  wbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wbps_window u_window (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_last_of_region (in_last_of_region),
    .cfg               (cfg),
    .take              (take),
    .s1_valid          (s1_valid),
    .s1                (s1),
    .window            (window)
  );

  wbps_match u_match (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1_valid          (s1_valid),
    .s1                (s1),
    .window            (window),
    .cfg               (cfg),
    .take              (take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_match_offset  (out_match_offset),
    .out_match_address (out_match_address)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the wildcard byte pattern scanner top level.
module tb;
  import wbps_pkg::*;

  localparam int LATENCY       = 1;
  localparam int SETTLE_CYCLES = LATENCY + 3;
  localparam int LONG_HOLD     = 200;
  localparam int RANDOM_ITEMS  = 1300;

  // One reported match
  typedef struct packed {
    logic [OUT_OFF_W-1:0] match_off;
    logic [ADDR_W-1:0]    match_addr;
  } match_t;

  // Receiver stall patterns
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_byte_value = '0;
  logic                  in_last_of_region = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_OFF_W-1:0]  out_match_offset;
  logic [ADDR_W-1:0]     out_match_address;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PAT_LOW;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Mirror of the block's registers and scan state
  logic [63:0]            cur_pattern_low = '0;
  logic [63:0]            cur_pattern_high = '0;
  logic [15:0]            cur_care = '0;
  logic [LEN_W-1:0]       cur_length = '0;
  logic [ADDR_W-1:0]      cur_base = '0;
  window_t                recent_bytes = '0;
  logic [OFFSET_BITS-1:0] region_pos = '0;

  match_t pending_matches[$];
  match_t oldest_match;
  int     mismatch_count = 0;
  int     bytes_sent = 0;
  int     burst_left = 0;

  // Receiver state
  rx_mode_e rx_mode = RX_ALWAYS;
  int       rx_mode_left = 0;
  int       rx_cycle = 0;
  int       hold_left = 0;
  bit       hold_toggle = 1'b0;
  bit       hold_seen = 1'b0;

  wildcard_byte_pattern_scanner_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_last_of_region (in_last_of_region),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_match_offset  (out_match_offset),
    .out_match_address (out_match_address),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shift one byte into the window and queue the match it completes, if any
  function automatic void scan_byte(input logic [7:0] b, input logic last);
    logic [PAT_BYTES-1:0][7:0] pat;
    logic [63:0] pos;
    logic [63:0] len;
    logic [63:0] off;
    logic        hit;
    match_t      m;
    pat = {cur_pattern_high, cur_pattern_low};
    recent_bytes = {recent_bytes[MAX_PATTERN-2:0], b};
    pos = 64'(region_pos);
    len = 64'(cur_length);
    if (len >= 1 && len <= PAT_LIMIT && pos + 1 >= len) begin
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (cur_care[j] && recent_bytes[len - 1 - j] != pat[j])
          hit = 1'b0;
      end
      if (hit) begin
        off = pos + 1 - len;
        m.match_off  = off[OUT_OFF_W-1:0];
        m.match_addr = cur_base + off;
        pending_matches = {pending_matches, m};
      end
    end
    // Clear at region end, otherwise count up and saturate
    if (last)
      region_pos = '0;
    else if (region_pos != '1)
      region_pos = region_pos + OFFSET_BITS'(1);
  endfunction

  // Byte from a three-value alphabet when few_values, else any byte
  function automatic logic [7:0] pick_byte(input bit few_values);
    if (!few_values)
      return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'h5A;
    endcase
  endfunction

  // Offer one item, idling between bursts, and wait for its handshake
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_byte_value     <= b;
    in_last_of_region <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_byte(b, last);
    bytes_sent++;
  endtask

  // Drop valid and wait until every queued match has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write every register and update the mirror; block must be idle
  task automatic load_scan_setup(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [15:0] care, input logic [LEN_W-1:0] len,
                                 input logic [63:0] base);
    write_reg(CFG_PAT_LOW, lo);
    write_reg(CFG_PAT_HIGH, hi);
    write_reg(CFG_CARE, 64'(care));
    write_reg(CFG_LENGTH, 64'(len));
    write_reg(CFG_BASE, base);
    cfg_we <= 1'b0;
    cur_pattern_low  = lo;
    cur_pattern_high = hi;
    cur_care         = care;
    cur_length       = len;
    cur_base         = base;
  endtask

  // Length zero straight after reset gives no match
  task automatic test_reset_state_no_match();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Full sixteen-byte pattern at offset one, base wraps the address to zero
  task automatic test_full_width_pattern();
    logic [PAT_BYTES-1:0][7:0] pat;
    logic [63:0] lo;
    logic [63:0] hi;
    lo  = 64'h807F_01FE_55AA_FF00;
    hi  = 64'hC33C_9669_0FF0_00FF;
    pat = {hi, lo};
    settle();
    load_scan_setup(lo, hi, 16'hFFFF, 5'd16, '1);
    send_byte(8'h3C, 1'b0);
    for (int j = 0; j < PAT_BYTES; j++)
      send_byte(pat[j], j == PAT_BYTES - 1);
  endtask

  // All-wildcard single byte: every byte matches, region end clears the offset
  task automatic test_wildcard_every_byte();
    settle();
    load_scan_setup({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd1,
                    64'h0000_0000_0000_1000);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b1);
    send_byte(8'h00, 1'b0);
  endtask

  // Overlapping matches; care bits above the length are ignored
  task automatic test_overlapping_matches();
    settle();
    load_scan_setup(64'h0000_0000_0000_AAAA, 64'h0, 16'hFFFF, 5'd2, 64'h0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  // Receiver holds off for a long stretch while every byte makes a match
  task automatic test_output_backpressure();
    settle();
    load_scan_setup({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd1,
                    {$urandom, $urandom});
    hold_toggle <= ~hold_toggle;
    repeat (80)
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    settle();
  endtask

  // Random setups; streams are mostly pattern instances with random wildcards
  task automatic test_random_streams();
    logic [PAT_BYTES-1:0][7:0] pat;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [63:0]      base;
    logic [15:0]      care;
    logic [LEN_W-1:0] len;
    bit               few_values;
    int               start;
    int               phase_items;
    int               kind;
    int               span;
    int               cut;
    int               first;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_ITEMS) begin
      few_values = ($urandom_range(0, 2) == 0);
      for (int j = 0; j < PAT_BYTES; j++)
        pat[j] = pick_byte(few_values);
      {hi, lo} = pat;
      case ($urandom_range(0, 11))
        0: len = 5'd0;
        1: len = 5'($urandom_range(17, 31));
        2: len = 5'd16;
        3: len = 5'd1;
        default: len = 5'($urandom_range(2, 15));
      endcase
      case ($urandom_range(0, 3))
        0: care = 16'hFFFF;
        1: care = 16'h0000;
        default: care = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: base = '1;
        1: base = 64'h0 - 64'($urandom_range(1, 200));
        2: base = '0;
        default: base = {$urandom, $urandom};
      endcase
      settle();
      load_scan_setup(lo, hi, care, len, base);
      phase_items = $urandom_range(60, 160);
      start = bytes_sent;
      while (bytes_sent - start < phase_items) begin
        kind = $urandom_range(0, 9);
        span = (len >= 1 && len <= 16) ? int'(len) : $urandom_range(1, 16);
        if (kind <= 5) begin
          for (int j = 0; j < span; j++)
            send_byte(care[j] ? pat[j] : pick_byte(few_values),
                      (j == span - 1) ? ($urandom_range(0, 7) == 0)
                                      : ($urandom_range(0, 29) == 0));
        end else if (kind <= 7) begin
          // Broken instance: a prefix, then an arbitrary byte
          cut = $urandom_range(0, span - 1);
          for (int j = 0; j < cut; j++)
            send_byte(care[j] ? pat[j] : pick_byte(few_values), 1'b0);
          send_byte(pick_byte(few_values), $urandom_range(0, 19) == 0);
        end else begin
          repeat ($urandom_range(1, 6))
            send_byte(pick_byte(few_values && $urandom_range(0, 1)),
                      $urandom_range(0, 19) == 0);
        end
      end
    end
  endtask

  // Receiver: stall pattern changes now and then; long hold on request
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 150);
    end
    rx_mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= rx_cycle[2];
      endcase
    end
  end

  // Compare each accepted result with the oldest queued match
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: result with none pending, offset %h address %h",
                 $time, out_match_offset, out_match_address);
        mismatch_count++;
      end else begin
        oldest_match = pending_matches.pop_front();
        if (out_match_offset !== oldest_match.match_off) begin
          $display("%0t: match_offset expected %h got %h",
                   $time, oldest_match.match_off, out_match_offset);
          mismatch_count++;
        end
        if (out_match_address !== oldest_match.match_addr) begin
          $display("%0t: match_address expected %h got %h",
                   $time, oldest_match.match_addr, out_match_address);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #3000000;
    $display("wildcard_byte_pattern_scanner_unit: mismatch");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state_no_match();
    test_full_width_pattern();
    test_wildcard_every_byte();
    test_overlapping_matches();
    test_output_backpressure();
    test_random_streams();
    settle();
    if (mismatch_count == 0)
      $display("wildcard_byte_pattern_scanner_unit: match");
    else
      $display("wildcard_byte_pattern_scanner_unit: mismatch");
    $finish;
  end

endmodule
